### design/pointer_angle_degrees_defines.svh
// ----------------------------------------------------------------------------
// Pointer angle assertion macros
// Shared assertion forms for the pointer angle checker.
// ----------------------------------------------------------------------------
`ifndef POINTER_ANGLE_DEGREES_DEFINES_SVH
`define POINTER_ANGLE_DEGREES_DEFINES_SVH

// Property checked at every clock edge outside reset
`define PTRANG_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ptrang assertion failed");

// Property checked at every clock edge, reset included
`define PTRANG_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("ptrang assertion failed");

`endif

### design/ptrang_pkg.sv
// ----------------------------------------------------------------------------
// Pointer angle package
// Item types, fixed-point formats and the arctangent table of the CORDIC.
// ----------------------------------------------------------------------------
package ptrang_pkg;

  // Coordinate and angle formats
  localparam int COORD_BITS      = 12;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int ANGLE_W         = 17;
  localparam int TURN_W          = 32;
  localparam int XY_FRAC         = 32;
  // sign, coordinate magnitude, headroom for the CORDIC gain, fraction
  localparam int XY_W            = COORD_BITS + 4 + XY_FRAC;
  localparam int DEG_W           = 9;
  localparam int DEG_PROD_W      = TURN_W + DEG_W;
  localparam int SCALE_W         = DEG_PROD_W + 16;
  localparam logic [DEG_W-1:0] DEG_FULL = 9'd360;

  // Binary angle constants, one full turn is 2^32
  localparam logic [TURN_W-1:0] TURN_ZERO     = 32'h0000_0000;
  localparam logic [TURN_W-1:0] TURN_QUARTER  = 32'h4000_0000;
  localparam logic [TURN_W-1:0] TURN_HALF     = 32'h8000_0000;
  localparam logic [TURN_W-1:0] TURN_3QUARTER = 32'hC000_0000;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] pointer_x;
    logic [COORD_BITS-1:0] pointer_y;
  } in_item_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_q8;
    logic               at_center;
  } out_item_t;

  // Vector and angle carried through the rotation stages
  typedef struct packed {
    logic                   bypass;
    logic                   at_center;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic [TURN_W-1:0]      z;
  } rot_t;

  // atan(2^-i) in binary angle units, rounded to nearest
  function automatic logic [TURN_W-1:0] atan_turns(input logic [4:0] idx);
    logic [TURN_W-1:0] val;
    case (idx)
      5'd0:  val = 32'h2000_0000;
      5'd1:  val = 32'h12E4_051E;
      5'd2:  val = 32'h09FB_385B;
      5'd3:  val = 32'h0511_11D4;
      5'd4:  val = 32'h028B_0D43;
      5'd5:  val = 32'h0145_D7E1;
      5'd6:  val = 32'h00A2_F61E;
      5'd7:  val = 32'h0051_7C55;
      5'd8:  val = 32'h0028_BE53;
      5'd9:  val = 32'h0014_5F2F;
      5'd10: val = 32'h000A_2F98;
      5'd11: val = 32'h0005_17CC;
      5'd12: val = 32'h0002_8BE6;
      5'd13: val = 32'h0001_45F3;
      5'd14: val = 32'h0000_A2FA;
      5'd15: val = 32'h0000_517D;
      5'd16: val = 32'h0000_28BE;
      5'd17: val = 32'h0000_145F;
      5'd18: val = 32'h0000_0A30;
      5'd19: val = 32'h0000_0518;
      5'd20: val = 32'h0000_028C;
      5'd21: val = 32'h0000_0146;
      5'd22: val = 32'h0000_00A3;
      5'd23: val = 32'h0000_0051;
      5'd24: val = 32'h0000_0029;
      5'd25: val = 32'h0000_0014;
      5'd26: val = 32'h0000_000A;
      5'd27: val = 32'h0000_0005;
      5'd28: val = 32'h0000_0003;
      5'd29: val = 32'h0000_0001;
      5'd30: val = 32'h0000_0001;
      default: val = 32'h0000_0000;
    endcase
    return val;
  endfunction

endpackage

### design/ptrang_prep.sv
// ----------------------------------------------------------------------------
// Pointer angle front stage
// Forms the offset from the centre, folds the left half plane and flags the
// centre and axis cases, then registers the start vector.
// ----------------------------------------------------------------------------
module ptrang_prep (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  ptrang_pkg::in_item_t                 in_data,
  input  logic [ptrang_pkg::COORD_BITS-1:0]    center_x,
  input  logic [ptrang_pkg::COORD_BITS-1:0]    center_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ptrang_pkg::rot_t                     out_data
);

  logic signed [ptrang_pkg::COORD_BITS:0] dx;
  logic signed [ptrang_pkg::COORD_BITS:0] dy;
  logic signed [ptrang_pkg::COORD_BITS:0] fx;
  logic signed [ptrang_pkg::COORD_BITS:0] fy;
  logic signed [ptrang_pkg::XY_W-1:0]     wx;
  logic signed [ptrang_pkg::XY_W-1:0]     wy;
  logic                                   left;
  ptrang_pkg::rot_t                       start;

  // Offset with y turned to grow upward
  assign dx = $signed({1'b0, in_data.pointer_x}) - $signed({1'b0, center_x});
  assign dy = $signed({1'b0, center_y}) - $signed({1'b0, in_data.pointer_y});

  // Turn left half plane vectors by half a turn
  assign left = dx[ptrang_pkg::COORD_BITS];
  assign fx   = left ? -dx : dx;
  assign fy   = left ? -dy : dy;
  assign wx   = ptrang_pkg::XY_W'(fx);
  assign wy   = ptrang_pkg::XY_W'(fy);

  always_comb begin
    start.at_center = (dx == '0) && (dy == '0);
    start.bypass    = (dx == '0) || (dy == '0);
    start.x         = wx <<< ptrang_pkg::XY_FRAC;
    start.y         = wy <<< ptrang_pkg::XY_FRAC;
    // Exact angles on the axes, rotation start angle otherwise
    if (start.at_center) begin
      start.z = ptrang_pkg::TURN_ZERO;
    end else if (dy == '0) begin
      start.z = left ? ptrang_pkg::TURN_HALF : ptrang_pkg::TURN_ZERO;
    end else if (dx == '0) begin
      start.z = dy[ptrang_pkg::COORD_BITS] ? ptrang_pkg::TURN_3QUARTER
                                            : ptrang_pkg::TURN_QUARTER;
    end else begin
      start.z = left ? ptrang_pkg::TURN_HALF : ptrang_pkg::TURN_ZERO;
    end
  end

  // Advance when the register is empty or drains this cycle
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= start;
    end
  end

endmodule

### design/ptrang_stage.sv
// ----------------------------------------------------------------------------
// Pointer angle rotation stage
// One vectoring micro-rotation of the CORDIC with its pipeline register.
// ----------------------------------------------------------------------------
module ptrang_stage #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ptrang_pkg::rot_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ptrang_pkg::rot_t  out_data
);

  localparam logic [4:0] TAB_IDX = 5'(IDX);

  logic signed [ptrang_pkg::XY_W-1:0] xs;
  logic signed [ptrang_pkg::XY_W-1:0] ys;
  logic [ptrang_pkg::TURN_W-1:0]      step;
  ptrang_pkg::rot_t                   rot_next;

  // Floor shifts of the incoming vector
  assign xs   = in_data.x >>> IDX;
  assign ys   = in_data.y >>> IDX;
  assign step = ptrang_pkg::atan_turns(TAB_IDX);

  // Rotate toward the x axis, hold axis and centre items
  always_comb begin
    rot_next = in_data;
    if (!in_data.bypass) begin
      if (!in_data.y[ptrang_pkg::XY_W-1]) begin
        rot_next.x = in_data.x + ys;
        rot_next.y = in_data.y - xs;
        rot_next.z = in_data.z + step;
      end else begin
        rot_next.x = in_data.x - ys;
        rot_next.y = in_data.y + xs;
        rot_next.z = in_data.z - step;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= rot_next;
    end
  end

endmodule

### design/ptrang_scale.sv
// ----------------------------------------------------------------------------
// Pointer angle output stage
// Scales the binary angle to degrees with fraction bits and holds the result
// item in the output register.
// ----------------------------------------------------------------------------
module ptrang_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ptrang_pkg::rot_t      in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ptrang_pkg::out_item_t out_data
);

  logic [ptrang_pkg::DEG_PROD_W-1:0] prod;
  logic [ptrang_pkg::SCALE_W-1:0]    scaled;
  ptrang_pkg::out_item_t             res_next;

  // Degrees = turns * 360 * 2^frac / 2^32, truncated
  assign prod   = ptrang_pkg::DEG_PROD_W'(in_data.z) *
                  ptrang_pkg::DEG_PROD_W'(ptrang_pkg::DEG_FULL);
  assign scaled = ptrang_pkg::SCALE_W'(prod) << ptrang_pkg::ANGLE_FRAC_BITS;

  always_comb begin
    res_next.at_center = in_data.at_center;
    res_next.angle_q8  = in_data.at_center ? '0
                         : scaled[ptrang_pkg::TURN_W +: ptrang_pkg::ANGLE_W];
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

endmodule

### design/pointer_angle_degrees.sv
// ----------------------------------------------------------------------------
// Pointer angle in degrees
// Counter-clockwise angle of a screen pointer around a configured centre.
// ----------------------------------------------------------------------------
// Input items (in_valid/in_ready/in_data) carry a pointer position in pixels,
// y growing downward. Each gives one result item (out_valid/out_ready/
// out_data): the angle in degrees with 8 fraction bits, truncated, and a flag
// when the pointer sits on the centre (angle then 0).
// The centre is set through the APB port: center_x at 0x0, center_y at 0x4.
// Write it only while no item is in flight.
// An accepted item is loaded into the front stage register, then passes one
// register per CORDIC micro-rotation and the scaling output stage.
// Throughput is one item per cycle; every stage is a register with its own
// valid bit, so a new item enters each cycle while any stage has room.
// When the receiver holds out_ready low, the result stays in the output
// register and items pack up behind it; in_ready falls once all stages fill.
// Reset clears all valid bits and both centre registers to 0.
// ----------------------------------------------------------------------------
module pointer_angle_degrees #(
  parameter int CORDIC_STAGES = 18
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ptrang_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ptrang_pkg::out_item_t             out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ptrang_pkg::ADDR_W-1:0]     paddr,
  input  logic [ptrang_pkg::DATA_W-1:0]     pwdata,
  output logic [ptrang_pkg::DATA_W-1:0]     prdata,
  output logic                              pready
);

  logic [ptrang_pkg::COORD_BITS-1:0] center_x;
  logic [ptrang_pkg::COORD_BITS-1:0] center_y;
  logic                              reg_sel;

  logic             rot_valid [0:CORDIC_STAGES];
  logic             rot_ready [0:CORDIC_STAGES];
  ptrang_pkg::rot_t rot_data  [0:CORDIC_STAGES];

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        ptrang_pkg::REG_CENTER_X: center_x <= pwdata[ptrang_pkg::COORD_BITS-1:0];
        ptrang_pkg::REG_CENTER_Y: center_y <= pwdata[ptrang_pkg::COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ptrang_pkg::REG_CENTER_X: prdata = ptrang_pkg::DATA_W'(center_x);
      ptrang_pkg::REG_CENTER_Y: prdata = ptrang_pkg::DATA_W'(center_y);
      default:                  prdata = '0;
    endcase
  end

  // Front stage
  ptrang_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .center_x  (center_x),
    .center_y  (center_y),
    .out_valid (rot_valid[0]),
    .out_ready (rot_ready[0]),
    .out_data  (rot_data[0])
  );

  // Micro-rotation chain
  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    ptrang_stage #(
      .IDX (k)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (rot_valid[k]),
      .in_ready  (rot_ready[k]),
      .in_data   (rot_data[k]),
      .out_valid (rot_valid[k+1]),
      .out_ready (rot_ready[k+1]),
      .out_data  (rot_data[k+1])
    );
  end

  // Scaling and output register
  ptrang_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid[CORDIC_STAGES]),
    .in_ready  (rot_ready[CORDIC_STAGES]),
    .in_data   (rot_data[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### design/ptrang_checker.sv
// ----------------------------------------------------------------------------
// Pointer angle port checker
// Watches the top level ports for stalls, reset and result ranges.
// ----------------------------------------------------------------------------
`include "pointer_angle_degrees_defines.svh"

module ptrang_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input ptrang_pkg::out_item_t         out_data
);

  localparam logic [ptrang_pkg::ANGLE_W-1:0] ANGLE_LIMIT =
    ptrang_pkg::ANGLE_W'(360 << ptrang_pkg::ANGLE_FRAC_BITS);

  // Hold a stalled result item
  `PTRANG_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // Back-pressure comes only from a stalled output
  `PTRANG_ASSERT(a_stall_source, clk, rst, !in_ready |-> out_valid && !out_ready)

  // Centre items read zero, all angles stay below a full turn
  `PTRANG_ASSERT(a_angle_range, clk, rst, out_valid |-> (out_data.angle_q8 < ANGLE_LIMIT) && (!out_data.at_center || out_data.angle_q8 == '0))

  // Drop all items on reset
  `PTRANG_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind pointer_angle_degrees ptrang_checker u_checker (.*);
